FILE: rtl/psir_pkg.sv
// Shared types, constants and register indexes for the period speed integral regulator.
package psir_pkg;

   localparam int DRIVE_WIDTH_DEFAULT = 16;

   localparam int RATE_NUMERATOR = 1000000;
   localparam int RATE_W         = 20;
   localparam int PERIOD_W       = 16;
   localparam int TARGET_W       = 16;
   localparam int DRIVE_OUT_W    = 16;
   localparam int GAIN_W         = 8;
   localparam int DIFF_W         = RATE_W + 1;
   localparam int ERR_W          = DIFF_W - 2;
   localparam int PROD_W         = GAIN_W + 1 + ERR_W;
   localparam int CNT_W          = $clog2(RATE_W + 1);

   localparam int GAIN_RESET    = 3;
   localparam int FLOOR_RESET   = 1000;
   localparam int CEILING_RESET = 1440;
   localparam int DRIVE_RESET   = 500;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_GAIN     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_FLOOR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_CEILING = 2'd2;

   typedef struct packed {
      logic [TARGET_W-1:0] target_rate;
      logic [PERIOD_W-1:0] measured_period;
   } psir_req_type;

   typedef struct packed {
      logic [DRIVE_OUT_W-1:0] drive_value;
      logic                   period_fault;
   } psir_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } psir_div_status_type;

endpackage

FILE: rtl/psir_divider.sv
// Restoring divider: constant rate numerator over the measured period, one quotient bit a cycle.
module psir_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [psir_pkg::PERIOD_W-1:0]       divisor,
   output logic [psir_pkg::RATE_W-1:0]         quotient,
   output psir_pkg::psir_div_status_type       status
);
   import psir_pkg::*;

   localparam logic [RATE_W-1:0] NUMERATOR = RATE_W'(RATE_NUMERATOR);

   logic [RATE_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;
   logic                take;

   assign trial = {rem_ff, quo_ff[RATE_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign take  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = NUMERATOR;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[RATE_W-2:0], take};
         rem_in = take ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RATE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: rtl/period_speed_integral_regulator_unit.sv
// Period speed integral regulator: sequencer, error scaling, gain, clamp and result register.
//
// Usage: present one item on req_data with req_valid; it is accepted at a rising edge
// where req_valid is high and req_stall is low. Each item gives exactly one result on
// rsp_data with rsp_valid, taken at an edge where rsp_stall is low.
// The measured rate comes from a restoring divider that retires one quotient bit per
// cycle over 20 bits; error scaling, gain multiply and clamp then follow, one state each.
// A normal item runs through the divider and the ERR, MUL, SUM and OUT states; a zero
// period skips the divider and goes from idle straight to OUT. The next item is
// accepted once the result is loaded and the sequencer is back in idle.
// One item is in work at a time: req_stall stays high until the sequencer is idle.
// The result register holds one finished item; while the receiver stalls it, the next
// item may be accepted and worked, and its result waits until the register frees.
// Configuration writes on csr_wr_en/csr_index/csr_wdata are taken at once; indexes
// beyond the register list are dropped. Write only while no item is in work.
// Reset (synchronous, active high) sets gain 3, floor 1000, ceiling 1440, the drive
// accumulator to 500 (saturated to DRIVE_WIDTH) and empties the result register.
module period_speed_integral_regulator_unit #(
   parameter int DRIVE_WIDTH = psir_pkg::DRIVE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  psir_pkg::psir_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output psir_pkg::psir_rsp_type               rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [psir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [psir_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import psir_pkg::*;

   localparam int SUM_W = (DRIVE_WIDTH > PROD_W - 1) ? DRIVE_WIDTH + 2 : PROD_W + 1;
   localparam longint unsigned DRIVE_MAX = (64'd1 << DRIVE_WIDTH) - 64'd1;
   localparam logic [DRIVE_WIDTH-1:0] ACC_RESET =
      DRIVE_WIDTH'((longint'(DRIVE_RESET) > longint'(DRIVE_MAX)) ? DRIVE_MAX : DRIVE_RESET);
   localparam logic [SUM_W-1:0] SUM_DRIVE_MAX =
      {{(SUM_W-DRIVE_WIDTH){1'b0}}, {DRIVE_WIDTH{1'b1}}};

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_ERR  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [GAIN_W-1:0]         gain_ff;
   logic [DRIVE_OUT_W-1:0]    floor_ff;
   logic [DRIVE_OUT_W-1:0]    ceil_ff;
   logic [DRIVE_WIDTH-1:0]    acc_ff, acc_in;
   logic [TARGET_W-1:0]       target_ff, target_in;
   logic [PERIOD_W-1:0]       period_ff, period_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   psir_rsp_type              res_ff, res_in;
   psir_rsp_type              rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      div_start;
   logic [RATE_W-1:0]         div_quotient;
   psir_div_status_type       div_status;

   logic signed [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]         diff_adj;
   logic [SUM_W-1:0]          acc_wide;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   ceil_ext;
   logic signed [SUM_W-1:0]   floor_ext;
   logic signed [SUM_W-1:0]   lim;
   logic [DRIVE_WIDTH-1:0]    acc_next;
   logic [SUM_W-1:0]          next_wide;
   logic                      accept;
   logic                      slot_free;

   psir_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (period_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign diff     = $signed({{(DIFF_W-TARGET_W){1'b0}}, target_ff})
                   - $signed({1'b0, div_quotient});
   assign diff_adj = diff + {{(DIFF_W-2){1'b0}}, diff[DIFF_W-1], diff[DIFF_W-1]};

   assign acc_wide  = {{(SUM_W-DRIVE_WIDTH){1'b0}}, acc_ff};
   assign sum       = $signed(acc_wide) + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign ceil_ext  = $signed({{(SUM_W-DRIVE_OUT_W){1'b0}}, ceil_ff});
   assign floor_ext = $signed({{(SUM_W-DRIVE_OUT_W){1'b0}}, floor_ff});

   always_comb begin
      lim = sum;
      if (lim > ceil_ext) begin
         lim = ceil_ext;
      end
      if (lim < floor_ext) begin
         lim = floor_ext;
      end
   end

   assign acc_next  = ($unsigned(lim) > SUM_DRIVE_MAX) ? {DRIVE_WIDTH{1'b1}}
                                                       : lim[DRIVE_WIDTH-1:0];
   assign next_wide = {{(SUM_W-DRIVE_WIDTH){1'b0}}, acc_next};

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      target_in    = target_ff;
      period_in    = period_ff;
      err_in       = err_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               target_in = req_data.target_rate;
               period_in = req_data.measured_period;
               if (req_data.measured_period == '0) begin
                  res_in.drive_value  = acc_wide[DRIVE_OUT_W-1:0];
                  res_in.period_fault = 1'b1;
                  state_in            = S_OUT;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (!div_status.busy && !div_status.done) begin
               div_start = 1'b1;
            end
            if (div_status.done) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            err_in   = $signed(diff_adj[DIFF_W-1:2]);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = $signed({1'b0, gain_ff}) * err_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            acc_in              = acc_next;
            res_in.drive_value  = next_wide[DRIVE_OUT_W-1:0];
            res_in.period_fault = 1'b0;
            state_in            = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      period_ff <= period_in;
      err_ff    <= err_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= ACC_RESET;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_W'(GAIN_RESET);
         floor_ff     <= DRIVE_OUT_W'(FLOOR_RESET);
         ceil_ff      <= DRIVE_OUT_W'(CEILING_RESET);
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_LOOP_GAIN:     gain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_DRIVE_FLOOR:   floor_ff <= csr_wdata[DRIVE_OUT_W-1:0];
               REG_DRIVE_CEILING: ceil_ff  <= csr_wdata[DRIVE_OUT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
